// File: design/obbpt_pkg.sv
// obbpt_pkg: shared types, constants and arithmetic helpers for the oriented box test block
// no dependencies; imported by obbpt_lane, obbpt_merge, obb2d_overlap_and_point_test_top and tb
package obbpt_pkg;

  // coordinate and derived arithmetic widths
  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int DOT_BITS    = PROD_BITS + 1;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_LANES   = 4;

  // command codes; the fourth code has no meaning and changes nothing
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_OVERLAP = 2'd1,
    CMD_POINT   = 2'd2
  } cmd_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // input transfer payload
  typedef struct packed {
    logic [1:0] command;
    coord_t     corner0_x;
    coord_t     corner0_y;
    coord_t     corner1_x;
    coord_t     corner1_y;
    coord_t     corner2_x;
    coord_t     corner2_y;
    coord_t     corner3_x;
    coord_t     corner3_y;
  } in_item_t;

  // output transfer payload
  typedef struct packed {
    logic hit;
    logic reference_empty;
  } out_item_t;

  // load enables for the two lane register stages
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

  // what one lane reports to the merge stage
  typedef struct packed {
    logic separate;
    logic first_neg;
  } lane_res_t;

  // exact difference of two coordinates
  function automatic diff_t sub_f(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = DIFF_BITS'(a);
    eb = DIFF_BITS'(b);
    return ea - eb;
  endfunction

  // exact 2d dot product
  function automatic dot_t dot_f(vec_t a, vec_t b);
    prod_t px;
    prod_t py;
    px = PROD_BITS'(a.x) * PROD_BITS'(b.x);
    py = PROD_BITS'(a.y) * PROD_BITS'(b.y);
    return DOT_BITS'(px) + DOT_BITS'(py);
  endfunction

endpackage

// File: design/obbpt_lane.sv
// obbpt_lane: one projection lane; registers edge and offsets, then squared length and dots
// depends on obbpt_pkg
module obbpt_lane (
  input  logic                                           clk_i,
  input  obbpt_pkg::lane_ctl_t                           ctl_i,
  input  obbpt_pkg::vec_t                                e_i,
  input  obbpt_pkg::vec_t [obbpt_pkg::NUM_CORNERS-1:0]   d_i,
  output obbpt_pkg::lane_res_t                           res_o
);
  import obbpt_pkg::*;

  vec_t                   e_q;
  vec_t [NUM_CORNERS-1:0] d_q;
  dot_t                   len_q;
  dot_t                   dot_q [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] above;
  logic [NUM_CORNERS-1:0] below;

  // operand stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_en) begin
      e_q <= e_i;
      d_q <= d_i;
    end
  end

  // product stage: squared edge length and one dot per corner
  always_ff @(posedge clk_i) begin
    if (ctl_i.s2_en) begin
      len_q <= dot_f(e_q, e_q);
      for (int c = 0; c < NUM_CORNERS; c++) begin
        dot_q[c] <= dot_f(d_q[c], e_q);
      end
    end
  end

  // separated when every projection lies past the edge or before its start
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      above[c] = dot_q[c] > len_q;
      below[c] = dot_q[c][DOT_BITS-1];
    end
    res_o.separate  = (&above) | (&below);
    res_o.first_neg = below[0];
  end

endmodule

// File: design/obbpt_merge.sv
// obbpt_merge: combines the lane flags into the result and holds the output register
// depends on obbpt_pkg
module obbpt_merge (
  input  logic                                        clk_i,
  input  logic                                        load_i,
  input  logic [1:0]                                  cmd_i,
  input  logic                                        empty_i,
  input  obbpt_pkg::lane_res_t [obbpt_pkg::NUM_LANES-1:0] lane_res_i,
  output obbpt_pkg::out_item_t                        out_data_o
);
  import obbpt_pkg::*;

  out_item_t              res_d;
  out_item_t              res_q;
  logic [NUM_LANES-1:0]   sep;
  logic [NUM_LANES-1:0]   neg;

  // overlap needs no separating axis; point needs a non-empty reference and no negative cross product
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      sep[l] = lane_res_i[l].separate;
      neg[l] = lane_res_i[l].first_neg;
    end
    res_d.reference_empty = empty_i;
    unique case (cmd_i)
      CMD_OVERLAP: res_d.hit = ~(|sep);
      CMD_POINT:   res_d.hit = ~empty_i & ~(|neg);
      default:     res_d.hit = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule

// File: design/obb2d_overlap_and_point_test_top.sv
// obb2d_overlap_and_point_test_top: reference box store, operand selection, lanes and control
// depends on obbpt_pkg, obbpt_lane and obbpt_merge
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one command per transfer:
//   load stores four corners as the reference box, overlap runs the separating-axis test
//   of the given box against the reference, point tests corner 0 against the reference.
//   Output channel out_valid_o / out_stall_i / out_data_o returns one result per command
//   (hit, reference_empty), in command order.
//   A result passes the operand stage, product stage and output register before it is
//   presented. Throughput: one item per cycle while the receiver does not stall, set by
//   the four lanes each with its own multipliers working in parallel.
//   A load takes effect at its own transfer, so the very next item sees the new box.
//   When the receiver stalls, empty pipeline slots still fill; in_stall_o rises only
//   once the operand stage, product stage and output register all hold items.
//   Reset clears the reference box to all zeros (an empty box) and empties the pipeline.
module obb2d_overlap_and_point_test_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  obbpt_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output obbpt_pkg::out_item_t out_data_o
);
  import obbpt_pkg::*;

  coord_t ref_x_q [NUM_CORNERS];
  coord_t ref_y_q [NUM_CORNERS];
  coord_t cx [NUM_CORNERS];
  coord_t cy [NUM_CORNERS];

  logic       s1_vq, s2_vq, out_vq;
  logic [1:0] s1_cmd_q, s2_cmd_q;
  logic       s1_empty_q, s2_empty_q;
  logic       empty_d;
  logic       out_ready, s2_ready, s1_ready, in_xfer;

  lane_ctl_t                               lane_ctl;
  vec_t      [NUM_LANES-1:0]               lane_e;
  vec_t      [NUM_LANES-1:0][NUM_CORNERS-1:0] lane_d;
  lane_res_t [NUM_LANES-1:0]               lane_res;

  // pipeline flow control: a stage loads when it is empty or its content moves on
  assign out_ready  = ~out_vq | ~out_stall_i;
  assign s2_ready   = ~s2_vq | out_ready;
  assign s1_ready   = ~s1_vq | s2_ready;
  assign in_xfer    = in_valid_i & s1_ready;
  assign in_stall_o = ~s1_ready;
  assign out_valid_o = out_vq;

  assign lane_ctl.s1_en = s1_ready;
  assign lane_ctl.s2_en = s2_ready;

  // candidate corners as arrays
  always_comb begin
    cx[0] = in_data_i.corner0_x;  cy[0] = in_data_i.corner0_y;
    cx[1] = in_data_i.corner1_x;  cy[1] = in_data_i.corner1_y;
    cx[2] = in_data_i.corner2_x;  cy[2] = in_data_i.corner2_y;
    cx[3] = in_data_i.corner3_x;  cy[3] = in_data_i.corner3_y;
  end

  // empty flag as seen after a load in the same transfer
  always_comb begin
    if (in_data_i.command == CMD_LOAD) begin
      empty_d = (cx[1] == cx[0]) & (cy[1] == cy[0]);
    end else begin
      empty_d = (ref_x_q[1] == ref_x_q[0]) & (ref_y_q[1] == ref_y_q[0]);
    end
  end

  // reference box store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        ref_x_q[i] <= '0;
        ref_y_q[i] <= '0;
      end
    end else if (in_xfer && in_data_i.command == CMD_LOAD) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        ref_x_q[i] <= cx[i];
        ref_y_q[i] <= cy[i];
      end
    end
  end

  // lane operands: a sat axis per lane for overlap, an edge cross product per lane for a point
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      lane_d[0][c] = '{x: sub_f(cx[c], ref_x_q[0]), y: sub_f(cy[c], ref_y_q[0])};
      lane_d[1][c] = lane_d[0][c];
      lane_d[2][c] = '{x: sub_f(ref_x_q[c], cx[0]), y: sub_f(ref_y_q[c], cy[0])};
      lane_d[3][c] = lane_d[2][c];
    end
    lane_e[0] = '{x: sub_f(ref_x_q[1], ref_x_q[0]), y: sub_f(ref_y_q[1], ref_y_q[0])};
    lane_e[1] = '{x: sub_f(ref_x_q[3], ref_x_q[0]), y: sub_f(ref_y_q[3], ref_y_q[0])};
    lane_e[2] = '{x: sub_f(cx[1], cx[0]), y: sub_f(cy[1], cy[0])};
    lane_e[3] = '{x: sub_f(cx[3], cx[0]), y: sub_f(cy[3], cy[0])};
    if (in_data_i.command == CMD_POINT) begin
      // edge i crossed with (p - c[i]) as a dot with (py - yi, xi - px)
      for (int l = 0; l < NUM_LANES; l++) begin
        lane_e[l] = '{x: sub_f(ref_x_q[(l + 1) % NUM_CORNERS], ref_x_q[l]),
                      y: sub_f(ref_y_q[(l + 1) % NUM_CORNERS], ref_y_q[l])};
        for (int c = 0; c < NUM_CORNERS; c++) begin
          lane_d[l][c] = '{x: sub_f(cy[0], ref_y_q[l]), y: sub_f(ref_x_q[l], cx[0])};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq  <= 1'b0;
      s2_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (s1_ready)  s1_vq  <= in_valid_i;
      if (s2_ready)  s2_vq  <= s1_vq;
      if (out_ready) out_vq <= s2_vq;
    end
  end

  // command and empty flag travel beside the lanes
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_cmd_q   <= in_data_i.command;
      s1_empty_q <= empty_d;
    end
    if (s2_ready) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_empty_q <= s1_empty_q;
    end
  end

  // projection lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    obbpt_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .e_i   (lane_e[l]),
      .d_i   (lane_d[l]),
      .res_o (lane_res[l])
    );
  end

  // merge and output register
  obbpt_merge u_merge (
    .clk_i      (clk_i),
    .load_i     (out_ready),
    .cmd_i      (s2_cmd_q),
    .empty_i    (s2_empty_q),
    .lane_res_i (lane_res),
    .out_data_o (out_data_o)
  );

  // input stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vq && s2_vq && out_vq))
    else $error("input stalled with a free pipeline slot");

  // a point test against an empty reference never hits
  a_point_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vq && out_ready && s2_cmd_q == CMD_POINT && s2_empty_q)
      |=> (out_valid_o && !out_data_o.hit))
    else $error("point test hit on an empty reference");

  // a load reports no hit
  a_load_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vq && out_ready && s2_cmd_q == CMD_LOAD) |=> (out_valid_o && !out_data_o.hit))
    else $error("load produced a hit");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for obb2d_overlap_and_point_test_top (load, overlap, point and unused commands)
// depends on obbpt_pkg and the top level; a local box model predicts every result in order

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obbpt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // box with corners ordered around it, corner 0 first
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } box_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  box_t      model_ref_box;
  int        in_gap;
  int        out_gap;
  int        mismatches;
  int        cycle_count;

  obb2d_overlap_and_point_test_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock and cycle counter
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // box model
  // ---------------------------------------------------------------------------

  function automatic longint cx(box_t b, int i);
    return longint'($signed(b.x[i]));
  endfunction

  function automatic longint cy(box_t b, int i);
    return longint'($signed(b.y[i]));
  endfunction

  // edge k at corner 0 of box a splits box b off when all projections fall outside [0, len]
  function automatic logic edge_separates(box_t a, int k, box_t b);
    longint ex, ey, len, lo, hi, t;
    ex = cx(a, k) - cx(a, 0);
    ey = cy(a, k) - cy(a, 0);
    len = ex * ex + ey * ey;
    lo = 0;
    hi = 0;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      t = (cx(b, c) - cx(a, 0)) * ex + (cy(b, c) - cy(a, 0)) * ey;
      if (c == 0 || t < lo) lo = t;
      if (c == 0 || t > hi) hi = t;
    end
    return (lo > len) || (hi < 0);
  endfunction

  function automatic logic boxes_overlap(box_t a, box_t b);
    return !edge_separates(a, 1, b) && !edge_separates(a, 3, b) &&
           !edge_separates(b, 1, a) && !edge_separates(b, 3, a);
  endfunction

  function automatic logic box_is_empty(box_t b);
    return (b.x[1] == b.x[0]) && (b.y[1] == b.y[0]);
  endfunction

  // inside when no edge cross product is negative; an empty box holds nothing
  function automatic logic point_in_box(box_t r, longint px, longint py);
    longint cr;
    int j;
    if (box_is_empty(r)) return 1'b0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      j = (i + 1) % NUM_CORNERS;
      cr = (cx(r, j) - cx(r, i)) * (py - cy(r, i)) - (cy(r, j) - cy(r, i)) * (px - cx(r, i));
      if (cr < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic box_t box_of_item(in_item_t it);
    box_t b;
    b.x[0] = it.corner0_x;
    b.y[0] = it.corner0_y;
    b.x[1] = it.corner1_x;
    b.y[1] = it.corner1_y;
    b.x[2] = it.corner2_x;
    b.y[2] = it.corner2_y;
    b.x[3] = it.corner3_x;
    b.y[3] = it.corner3_y;
    return b;
  endfunction

  // expected result of one accepted command; updates the model's stored box
  function automatic out_item_t box_test_predict(in_item_t it);
    out_item_t res;
    box_t      given;
    given = box_of_item(it);
    res.hit = 1'b0;
    case (it.command)
      CMD_LOAD:    model_ref_box = given;
      CMD_OVERLAP: res.hit = boxes_overlap(model_ref_box, given);
      CMD_POINT:   res.hit = point_in_box(model_ref_box, cx(given, 0), cy(given, 0));
      default:     ;
    endcase
    res.reference_empty = box_is_empty(model_ref_box);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------

  function automatic box_t box_of(int x0, int y0, int x1, int y1,
                                  int x2, int y2, int x3, int y3);
    box_t b;
    b.x[0] = coord_t'(x0);
    b.y[0] = coord_t'(y0);
    b.x[1] = coord_t'(x1);
    b.y[1] = coord_t'(y1);
    b.x[2] = coord_t'(x2);
    b.y[2] = coord_t'(y2);
    b.x[3] = coord_t'(x3);
    b.y[3] = coord_t'(y3);
    return b;
  endfunction

  function automatic in_item_t item_of(logic [1:0] cmd, box_t b);
    in_item_t it;
    it.command   = cmd;
    it.corner0_x = b.x[0];
    it.corner0_y = b.y[0];
    it.corner1_x = b.x[1];
    it.corner1_y = b.y[1];
    it.corner2_x = b.x[2];
    it.corner2_y = b.y[2];
    it.corner3_x = b.x[3];
    it.corner3_y = b.y[3];
    return it;
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic box_t noise_box();
    box_t b;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      b.x[i] = coord_t'($urandom);
      b.y[i] = coord_t'($urandom);
    end
    return b;
  endfunction

  // mostly counterclockwise parallelograms at (px, py), some clockwise, degenerate or noise
  function automatic box_t random_box(int px, int py, int span);
    box_t b;
    int   ux, uy, vx, vy, m, kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) return noise_box();
    ux = rand_signed(span);
    uy = rand_signed(span);
    m  = $urandom_range(1, 4);
    vx = -uy * m / 2;
    vy = ux * m / 2;
    if (kind == 1) begin
      vx = -vx;
      vy = -vy;
    end
    b = box_of(px, py, px + ux, py + uy, px + ux + vx, py + uy + vy, px + vx, py + vy);
    // zero-length edge from corner 0 to corner 1 or to corner 3
    if (kind == 2) begin
      b.x[1] = b.x[0];
      b.y[1] = b.y[0];
    end else if (kind == 3) begin
      b.x[3] = b.x[0];
      b.y[3] = b.y[0];
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: presents queued items, random idle bursts
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(box_test_predict(in_data_i));
      // payload may only change when nothing is held or the last transfer completed
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() >= CALM_ITEMS && $urandom_range(0, 11) == 0) begin
          in_gap = $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: checks each transfer against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result: hit=%0b reference_empty=%0b",
                     out_data_o.hit, out_data_o.reference_empty);
          mismatches++;
        end else begin
          automatic out_item_t want = expected_results.pop_front();
          if (out_data_o.hit !== want.hit ||
              out_data_o.reference_empty !== want.reference_empty) begin
            if (mismatches < REPORT_MAX)
              $display("mismatch: expected hit=%0b reference_empty=%0b, got hit=%0b reference_empty=%0b",
                       want.hit, want.reference_empty,
                       out_data_o.hit, out_data_o.reference_empty);
            mismatches++;
          end
        end
      end
      // stall bursts, none near the end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (pending_items.size() >= CALM_ITEMS && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: directed items, random items, drain, verdict
  // ---------------------------------------------------------------------------

  initial begin
    automatic box_t gen_ref = '0;
    automatic box_t b;
    automatic int   r, span, wa, wb;
    automatic longint px, py;

    mismatches  = 0;
    cycle_count = 0;
    model_ref_box = '0;

    // empty box after reset
    pending_items.push_back(item_of(CMD_POINT, box_of(0, 0, 5, 5, 5, 5, 5, 5)));
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(-4, -4, 4, -4, 4, 4, -4, 4)));
    pending_items.push_back(item_of(CMD_UNUSED, noise_box()));

    // full coordinate range box
    b = box_of(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
    pending_items.push_back(item_of(CMD_LOAD, b));
    pending_items.push_back(item_of(CMD_POINT, box_of(0, 0, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_POINT, box_of(-32768, -32768, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_POINT, box_of(32767, 32767, 1, 2, 3, 4, 5, 6)));
    pending_items.push_back(item_of(CMD_OVERLAP, b));

    // small square: inside, outside, on the boundary
    pending_items.push_back(item_of(CMD_LOAD, box_of(0, 0, 10, 0, 10, 10, 0, 10)));
    pending_items.push_back(item_of(CMD_POINT, box_of(5, 5, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_POINT, box_of(11, 5, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_POINT, box_of(10, 10, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_POINT, box_of(-1, 0, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(10, 0, 20, 0, 20, 10, 10, 10)));
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(11, 0, 21, 0, 21, 10, 11, 10)));
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(5, -3, 13, 5, 5, 13, -3, 5)));
    // collapsed candidate box, all edges zero
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(5, 5, 5, 5, 5, 5, 5, 5)));
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(50, 50, 50, 50, 50, 50, 50, 50)));
    pending_items.push_back(item_of(CMD_OVERLAP,
        box_of(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767)));

    // clockwise order fails the point test
    pending_items.push_back(item_of(CMD_LOAD, box_of(0, 0, 0, 10, 10, 10, 10, 0)));
    pending_items.push_back(item_of(CMD_POINT, box_of(5, 5, 0, 0, 0, 0, 0, 0)));

    // empty reference: first edge zero
    pending_items.push_back(item_of(CMD_LOAD, box_of(3, 3, 3, 3, 9, 9, 1, 7)));
    pending_items.push_back(item_of(CMD_POINT, box_of(3, 3, 0, 0, 0, 0, 0, 0)));
    pending_items.push_back(item_of(CMD_OVERLAP, box_of(0, 0, 10, 0, 10, 10, 0, 10)));
    pending_items.push_back(item_of(CMD_UNUSED, noise_box()));

    // edge from corner 0 to corner 3 zero
    gen_ref = box_of(0, 0, 10, 0, 10, 10, 0, 0);
    pending_items.push_back(item_of(CMD_LOAD, gen_ref));

    // random part: mostly sensible boxes near the stored one
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      span = ($urandom_range(0, 9) == 0) ? 16000 : $urandom_range(1, 300);
      if (r < 12) begin
        if ($urandom_range(0, 7) == 0) b = random_box(rand_signed(32767), rand_signed(32767), span);
        else b = random_box(rand_signed(1000), rand_signed(1000), span);
        gen_ref = b;
        pending_items.push_back(item_of(CMD_LOAD, b));
      end else if (r < 50) begin
        b = random_box(int'(cx(gen_ref, 0)) + rand_signed(2 * span),
                       int'(cy(gen_ref, 0)) + rand_signed(2 * span), span);
        pending_items.push_back(item_of(CMD_OVERLAP, b));
      end else if (r < 88) begin
        // point as a blend of the edges from corner 0 to corners 1 and 3, partly outside
        wa = int'($urandom_range(0, 24)) - 4;
        wb = int'($urandom_range(0, 24)) - 4;
        px = cx(gen_ref, 0) + ((cx(gen_ref, 1) - cx(gen_ref, 0)) * wa +
                               (cx(gen_ref, 3) - cx(gen_ref, 0)) * wb) / 16;
        py = cy(gen_ref, 0) + ((cy(gen_ref, 1) - cy(gen_ref, 0)) * wa +
                               (cy(gen_ref, 3) - cy(gen_ref, 0)) * wb) / 16;
        b = noise_box();
        b.x[0] = coord_t'(px);
        b.y[0] = coord_t'(py);
        pending_items.push_back(item_of(CMD_POINT, b));
      end else if (r < 93) begin
        pending_items.push_back(item_of(CMD_UNUSED, noise_box()));
      end else begin
        b = noise_box();
        if (($urandom_range(0, 3) == 0)) gen_ref = b;
        pending_items.push_back(item_of(($urandom_range(0, 3) == 0) ? CMD_LOAD :
                                        2'($urandom_range(1, 3)), b));
      end
    end

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain
    while ((pending_items.size() > 0 || in_valid_i || expected_results.size() > 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk_i);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL obb2d_overlap_and_point_test_top");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (mismatches == 0 && expected_results.size() == 0) begin
        $display("PASS obb2d_overlap_and_point_test_top");
      end else begin
        $display("FAIL obb2d_overlap_and_point_test_top");
      end
    end
    $finish;
  end

endmodule

// File: filelist.f
design/obbpt_pkg.sv
design/obbpt_lane.sv
design/obbpt_merge.sv
design/obb2d_overlap_and_point_test_top.sv
bench/tb.sv
